### rtl/brsm_pkg.sv
// Shared constants for the radix-2 Booth signed multiplier.
// Holds the fixed port field widths and the Booth pair codes used by the cells.
// No dependencies.
package brsm_pkg;

  // Fixed field widths on the stream ports.
  localparam int OPERAND_W = 16;
  localparam int PRODUCT_W = 32;
  localparam int IN_TDATA_W = 2 * OPERAND_W;
  localparam int OUT_TDATA_W = PRODUCT_W;

  // Booth pair codes, written as {multiplier LSB, extra bit}.
  localparam logic [1:0] BOOTH_SUB = 2'b10;
  localparam logic [1:0] BOOTH_ADD = 2'b01;

endpackage

### rtl/brsm_cell.sv
// One Booth step cell of the multiplier chain: add or subtract, then shift.
// Holds one word's partial state and hands it on when the next cell is ready.
// Depends on brsm_pkg.
module brsm_cell #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_acc,
  input  logic [WIDTH-1:0] in_mplr,
  input  logic             in_extra,
  input  logic [WIDTH-1:0] in_mcand,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_acc,
  output logic [WIDTH-1:0] out_mplr,
  output logic             out_extra,
  output logic [WIDTH-1:0] out_mcand
);
  import brsm_pkg::*;

  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] mplr_next;

  // Booth recoding of the current pair picks subtract, add or hold.
  always_comb begin
    case ({in_mplr[0], in_extra})
      BOOTH_SUB: sum = in_acc - in_mcand;
      BOOTH_ADD: sum = in_acc + in_mcand;
      default:   sum = in_acc;
    endcase
    acc_next  = {sum[WIDTH-1], sum[WIDTH-1:1]};
    mplr_next = {sum[0], in_mplr[WIDTH-1:1]};
  end

  // The cell takes a new word when it is empty or its word moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload registers load only with a word.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_acc   <= acc_next;
      out_mplr  <= mplr_next;
      out_extra <= in_mplr[0];
      out_mcand <= in_mcand;
    end
  end

endmodule

### rtl/booth_radix2_signed_multiplier.sv
// Top level of the radix-2 Booth signed multiplier: a chain of WIDTH step cells.
// Depends on brsm_pkg and brsm_cell.
//
// Usage:
//   Operand words enter on the s_axis channel (multiplicand in tdata[15:0],
//   multiplier in tdata[31:16]); each gives one product word on m_axis
//   (tdata[31:0], signed). A word is taken when tvalid and tready are high.
//   An accepted word reaches m_axis_tvalid through all WIDTH cells, each of
//   which does one Booth step and registers it. Throughput is one word per
//   cycle while the receiver takes words: every cell holds a different word,
//   so a new pair can enter each cycle while older ones are still in the chain.
//   The last cell is the output register. When the receiver stalls, words
//   keep moving into empty cells behind it; s_axis_tready drops only once
//   every cell holds a word. Reset clears all valid bits, so the chain comes
//   up empty with s_axis_tready high and m_axis_tvalid low.
//   For WIDTH below 16 the operands are taken as their low WIDTH bits and the
//   product is sign-extended; above 16 the operands are sign-extended and the
//   product is cut to its low 32 bits.
module booth_radix2_signed_multiplier #(
  parameter int WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: multiplicand[15:0], multiplier[15:0].
  input  logic [brsm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: product[31:0].
  output logic [brsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import brsm_pkg::*;

  logic [OPERAND_W-1:0] in_mcand;
  logic [OPERAND_W-1:0] in_mplr;
  logic [WIDTH-1:0]     mcand_w;
  logic [WIDTH-1:0]     mplr_w;

  logic             valid_c [0:WIDTH];
  logic             ready_c [0:WIDTH];
  logic [WIDTH-1:0] acc_c   [0:WIDTH];
  logic [WIDTH-1:0] mplr_c  [0:WIDTH];
  logic             extra_c [0:WIDTH];
  logic [WIDTH-1:0] mcand_c [0:WIDTH];
  logic [WIDTH-1:0] cell_full;

  logic [2*WIDTH-1:0] prod_w;

  assign in_mcand = s_axis_tdata[OPERAND_W-1:0];
  assign in_mplr  = s_axis_tdata[IN_TDATA_W-1:OPERAND_W];

  // Fit the 16-bit operands to the datapath width.
  generate
    if (WIDTH <= OPERAND_W) begin : g_in_trunc
      assign mcand_w = in_mcand[WIDTH-1:0];
      assign mplr_w  = in_mplr[WIDTH-1:0];
    end else begin : g_in_sext
      assign mcand_w = {{(WIDTH-OPERAND_W){in_mcand[OPERAND_W-1]}}, in_mcand};
      assign mplr_w  = {{(WIDTH-OPERAND_W){in_mplr[OPERAND_W-1]}}, in_mplr};
    end
  endgenerate

  // Head of the chain: accumulator and extra bit start at zero.
  assign valid_c[0]  = s_axis_tvalid;
  assign acc_c[0]    = '0;
  assign mplr_c[0]   = mplr_w;
  assign extra_c[0]  = 1'b0;
  assign mcand_c[0]  = mcand_w;
  assign s_axis_tready = ready_c[0];
  assign ready_c[WIDTH] = m_axis_tready;

  // One cell per Booth step.
  genvar k;
  generate
    for (k = 0; k < WIDTH; k++) begin : g_cell
      brsm_cell #(.WIDTH(WIDTH)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (valid_c[k]),
        .in_ready  (ready_c[k]),
        .in_acc    (acc_c[k]),
        .in_mplr   (mplr_c[k]),
        .in_extra  (extra_c[k]),
        .in_mcand  (mcand_c[k]),
        .out_valid (valid_c[k+1]),
        .out_ready (ready_c[k+1]),
        .out_acc   (acc_c[k+1]),
        .out_mplr  (mplr_c[k+1]),
        .out_extra (extra_c[k+1]),
        .out_mcand (mcand_c[k+1])
      );
      assign cell_full[k] = valid_c[k+1];
    end
  endgenerate

  // Product is the accumulator over the shifted multiplier.
  assign prod_w = {acc_c[WIDTH], mplr_c[WIDTH]};
  assign m_axis_tvalid = valid_c[WIDTH];

  generate
    if (2 * WIDTH >= PRODUCT_W) begin : g_out_trunc
      assign m_axis_tdata = prod_w[PRODUCT_W-1:0];
    end else begin : g_out_sext
      assign m_axis_tdata = {{(PRODUCT_W-2*WIDTH){prod_w[2*WIDTH-1]}}, prod_w};
    end
  endgenerate

  // The chain comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Input backpressure only when every cell holds a word and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&cell_full) && !m_axis_tready)
    else $error("input stalled while the chain has room");

  // An accepted word lands in the first cell.
  a_accept_first: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> valid_c[1])
    else $error("accepted word lost at the first cell");

endmodule
